### src/apt_pkg.sv
// ============================================================================
// apt_pkg: shared types and constants for the affine point transform
// Coefficient widths, register map, reset values and lane control types.
// ============================================================================
package apt_pkg;

  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_COORD_WIDTH = 32;

  localparam int COEF_W = 32;

  localparam int NUM_REGS     = 6;
  localparam int APB_DATA_W   = 64;
  localparam int APB_ADDR_W   = 6;
  localparam int REG_ADDR_LSB = 3;
  localparam int REG_IDX_W    = APB_ADDR_W - REG_ADDR_LSB;

  localparam logic [REG_IDX_W-1:0] REG_X_ROWS01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_ROWS23 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_ROWS01 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_ROWS23 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_Z_ROWS01 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Z_ROWS23 = 3'd5;

  localparam logic [APB_DATA_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic [APB_DATA_W-1:0] rows01;
    logic [APB_DATA_W-1:0] rows23;
  } col_coef_t;

endpackage

### src/apt_point_if.sv
// ============================================================================
// apt_point_if: input point channel
// Valid/ready channel carrying one 3D point per transaction.
// ============================================================================
interface apt_point_if #(
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

### src/apt_moved_if.sv
// ============================================================================
// apt_moved_if: transformed point channel
// Valid/ready channel carrying one transformed point per transaction.
// ============================================================================
interface apt_moved_if #(
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] moved_x;
  logic signed [COORD_WIDTH-1:0] moved_y;
  logic signed [COORD_WIDTH-1:0] moved_z;

  modport source (output valid, output moved_x, output moved_y, output moved_z,
                  input ready);
  modport sink (input valid, input moved_x, input moved_y, input moved_z,
                output ready);
endinterface

### src/apt_lane.sv
// ============================================================================
// apt_lane: one result column of the transform
// Multiplies the point by one matrix column, sums, rescales, adds the row-3 coefficient and saturates.
// ============================================================================
module apt_lane #(
  parameter int FRAC_BITS   = apt_pkg::DEF_FRAC_BITS,
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  apt_pkg::lane_ctrl_t           ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  apt_pkg::col_coef_t            coef_i,
  output logic signed [COORD_WIDTH-1:0] moved_o
);
  import apt_pkg::*;

  localparam int PROD_W = COORD_WIDTH + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHF_W  = SUM_W - FRAC_BITS;
  localparam int RES_W  = ((SHF_W > COEF_W) ? SHF_W : COEF_W) + 1;

  localparam logic signed [RES_W-1:0] SAT_MAX =
    {{(RES_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN =
    {{(RES_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COEF_W-1:0] c0, c1, c2, c3;
  logic signed [PROD_W-1:0] p0_d, p1_d, p2_d;
  logic signed [PROD_W-1:0] p0_q, p1_q, p2_q;
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [RES_W-1:0]  shf, res;

  assign c0 = coef_i.rows01[COEF_W-1:0];
  assign c1 = coef_i.rows01[2*COEF_W-1:COEF_W];
  assign c2 = coef_i.rows23[COEF_W-1:0];
  assign c3 = coef_i.rows23[2*COEF_W-1:COEF_W];

  assign p0_d = point_x_i * c0;
  assign p1_d = point_y_i * c1;
  assign p2_d = point_z_i * c2;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  assign sum_d = SUM_W'(p0_q) + SUM_W'(p1_q) + SUM_W'(p2_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      sum_q <= sum_d;
    end
  end

  // The homogeneous w of one adds the row-3 coefficient after rescaling.
  assign shf = RES_W'($signed(sum_q[SUM_W-1:FRAC_BITS]));
  assign res = shf + RES_W'(c3);

  always_comb begin
    if (res > SAT_MAX) begin
      moved_o = SAT_MAX[COORD_WIDTH-1:0];
    end else if (res < SAT_MIN) begin
      moved_o = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      moved_o = res[COORD_WIDTH-1:0];
    end
  end

endmodule

### src/apt_merge.sv
// ============================================================================
// apt_merge: result merge and output skid buffer
// Joins the three lane results into one transaction behind an output
// register and a skid register.
// ============================================================================
module apt_merge #(
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          ready_o,
  input  logic signed [COORD_WIDTH-1:0] lane_x_i,
  input  logic signed [COORD_WIDTH-1:0] lane_y_i,
  input  logic signed [COORD_WIDTH-1:0] lane_z_i,
  apt_moved_if.source                   moved_o
);
  import apt_pkg::*;

  logic                          out_valid_q, out_valid_d;
  logic                          skid_valid_q, skid_valid_d;
  logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic signed [COORD_WIDTH-1:0] skid_x_q, skid_y_q, skid_z_q;
  logic                          pop;
  logic                          load_out_new, load_out_skid, load_skid;

  assign ready_o = !skid_valid_q;
  assign pop     = out_valid_q && moved_o.ready;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out_new  = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        load_out_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        load_out_new = 1'b1;
        out_valid_d  = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_new) begin
      out_x_q <= lane_x_i;
      out_y_q <= lane_y_i;
      out_z_q <= lane_z_i;
    end else if (load_out_skid) begin
      out_x_q <= skid_x_q;
      out_y_q <= skid_y_q;
      out_z_q <= skid_z_q;
    end
    if (load_skid) begin
      skid_x_q <= lane_x_i;
      skid_y_q <= lane_y_i;
      skid_z_q <= lane_z_i;
    end
  end

  assign moved_o.valid   = out_valid_q;
  assign moved_o.moved_x = out_x_q;
  assign moved_o.moved_y = out_y_q;
  assign moved_o.moved_z = out_z_q;

endmodule

### src/affine_point_transform.sv
// ============================================================================
// affine_point_transform: 3D point times a 4x4 affine matrix
// Pipelined row-vector by matrix transform in signed fixed point.
// ============================================================================
// Each transaction on point_i is a point (x, y, z) taken as (x, y, z, 1) and
// multiplied by the matrix held in the six 64-bit registers; the first three
// columns come out on moved_o, rescaled by FRAC_BITS with rounding toward
// minus infinity and saturated. Three column lanes run side by side, so one
// point is accepted every cycle while the output is not stalled. A result
// passes through the product register, loaded at the accepting edge, the sum
// register, the skid register when moved_o stalls, and the output register.
// Matrix registers sit at byte address 8*i and reset to the identity for 16
// fraction bits; write them only while no transaction is in flight.
module affine_point_transform #(
  parameter int FRAC_BITS   = apt_pkg::DEF_FRAC_BITS,
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  apt_point_if.sink                      point_i,
  apt_moved_if.source                    moved_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [apt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [apt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [apt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import apt_pkg::*;

  logic [APB_DATA_W-1:0] cfg_q [NUM_REGS];
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  logic       s1_valid_q, s1_valid_d;
  logic       s2_valid_q, s2_valid_d;
  logic       merge_ready;
  lane_ctrl_t lane_ctrl;
  col_coef_t  coef_x, coef_y, coef_z;

  logic signed [COORD_WIDTH-1:0] lane_x, lane_y, lane_z;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:REG_ADDR_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= REG_RESET[i];
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (reg_idx == REG_IDX_W'(i)) begin
          cfg_q[i] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (reg_idx == REG_IDX_W'(i)) begin
        prdata = cfg_q[i];
      end
    end
  end

  assign coef_x = '{rows01: cfg_q[REG_X_ROWS01], rows23: cfg_q[REG_X_ROWS23]};
  assign coef_y = '{rows01: cfg_q[REG_Y_ROWS01], rows23: cfg_q[REG_Y_ROWS23]};
  assign coef_z = '{rows01: cfg_q[REG_Z_ROWS01], rows23: cfg_q[REG_Z_ROWS23]};

  assign lane_ctrl.s2_en = !s2_valid_q || merge_ready;
  assign lane_ctrl.s1_en = !s1_valid_q || lane_ctrl.s2_en;
  assign point_i.ready   = lane_ctrl.s1_en;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (lane_ctrl.s1_en) begin
      s1_valid_d = point_i.valid;
    end
    if (lane_ctrl.s2_en) begin
      s2_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  apt_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_x (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .point_x_i (point_i.point_x),
    .point_y_i (point_i.point_y),
    .point_z_i (point_i.point_z),
    .coef_i    (coef_x),
    .moved_o   (lane_x)
  );

  apt_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_y (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .point_x_i (point_i.point_x),
    .point_y_i (point_i.point_y),
    .point_z_i (point_i.point_z),
    .coef_i    (coef_y),
    .moved_o   (lane_y)
  );

  apt_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_lane_z (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .point_x_i (point_i.point_x),
    .point_y_i (point_i.point_y),
    .point_z_i (point_i.point_z),
    .coef_i    (coef_z),
    .moved_o   (lane_z)
  );

  apt_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (s2_valid_q),
    .ready_o  (merge_ready),
    .lane_x_i (lane_x),
    .lane_y_i (lane_y),
    .lane_z_i (lane_z),
    .moved_o  (moved_o)
  );

endmodule

### src/apt_checker.sv
// ============================================================================
// apt_checker: port-level checks for the affine point transform
// Watches the channels and the register port of the top level over time.
// ============================================================================
module apt_checker #(
  parameter int COORD_WIDTH = apt_pkg::DEF_COORD_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [COORD_WIDTH-1:0]         out_x_i,
  input logic [COORD_WIDTH-1:0]         out_y_i,
  input logic [COORD_WIDTH-1:0]         out_z_i,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic                           pready,
  input logic [apt_pkg::APB_ADDR_W-1:0] paddr,
  input logic [apt_pkg::APB_DATA_W-1:0] pwdata,
  input logic [apt_pkg::APB_DATA_W-1:0] prdata
);
  import apt_pkg::*;

  logic in_acc;
  logic cfg_wr_known;

  assign in_acc       = in_valid_i && in_ready_i;
  assign cfg_wr_known = psel && penable && pwrite && pready &&
                        (paddr[APB_ADDR_W-1:REG_ADDR_LSB] < REG_IDX_W'(NUM_REGS));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_x_i, out_y_i, out_z_i}))
    else $error("output payload changed while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc, 3))
    else $error("output appeared without a matching input three cycles earlier");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_known ##1 (psel && !pwrite && (paddr == $past(paddr)))
      |-> (prdata == $past(pwdata)))
    else $error("register readback differs from the value written");

endmodule

bind affine_point_transform apt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_apt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .out_valid_i (moved_o.valid),
  .out_ready_i (moved_o.ready),
  .out_x_i     (moved_o.moved_x),
  .out_y_i     (moved_o.moved_y),
  .out_z_i     (moved_o.moved_z),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pready      (pready),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
